[hdl/srfs_pkg.sv]
// shared types, constants and command/status bundles for the face selector
// no dependencies; imported by every module of the block
package srfs_pkg;

    // default sizing of the face table and counters
    localparam int NUM_FACES_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int MASK_FACES = 16;
    localparam int OPC_W      = 2;
    localparam int FACE_W     = 4;
    localparam int RATIO_W    = 10;
    localparam int TICKS_W    = 16;
    localparam int CFG_W      = 16;

    // ratio arithmetic
    localparam int RATIO_MAX  = 1000;
    localparam int QUOT_BITS  = 10;
    localparam int PCT_EXTRA  = 7;

    // register reset values
    localparam int THRESH_RST = 50;
    localparam int TICKS_RST  = 999;

    typedef logic [MASK_FACES-1:0] t_mask;

    typedef enum logic [OPC_W-1:0] {
        OP_REQUEST  = 2'd0,
        OP_RESPONSE = 2'd1,
        OP_TICK     = 2'd2
    } t_opcode;

    typedef enum logic {
        CFG_RATIO_THRESHOLD = 1'b0,
        CFG_WINDOW_TICKS    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_UPD,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec_item;
        logic walk_start;
        logic face_skip;
        logic face_load;
        logic div_prep;
        logic div_step;
        logic face_update;
        logic walk_finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic win_end;
        logic out_free;
        logic face_zero;
        logic last_face;
        logic div_sat;
        logic div_last;
    } t_status;

endpackage

[hdl/srfs_ctrl.sv]
// sequencing state machine of the face selector
// depends on srfs_pkg for the state, command and status types
module srfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  srfs_pkg::t_status i_status,
    output srfs_pkg::t_cmd    o_cmd
);
    import srfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.win_end) begin
                    o_cmd.walk_start = 1'b1;
                    n_state = S_LOAD;
                end else if (i_status.out_free) begin
                    o_cmd.exec_item = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                if (i_status.face_zero) begin
                    o_cmd.face_skip = 1'b1;
                    n_state = i_status.last_face ? S_FIN : S_LOAD;
                end else begin
                    o_cmd.face_load = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_state = i_status.div_sat ? S_UPD : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.face_update = 1'b1;
                n_state = i_status.last_face ? S_FIN : S_LOAD;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.walk_finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/srfs_datapath.sv]
// counters, window timer, ratio divider, best-face tracking and result register
// depends on srfs_pkg; driven by srfs_ctrl through command and status bundles
module srfs_datapath #(
    parameter int NUM_FACES  = srfs_pkg::NUM_FACES_DEF,
    parameter int COUNT_BITS = srfs_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [srfs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [srfs_pkg::OPC_W-1:0]     i_opcode,
    input  logic [srfs_pkg::FACE_W-1:0]    i_face_index,
    input  logic [srfs_pkg::MASK_FACES-1:0] i_eligible_mask,
    input  logic                           i_stall,
    input  srfs_pkg::t_cmd                 i_cmd,
    output srfs_pkg::t_status              o_status,
    output logic                           o_valid,
    output logic [srfs_pkg::MASK_FACES-1:0] o_forward_mask,
    output logic                           o_flooded,
    output logic [srfs_pkg::FACE_W-1:0]    o_best_face,
    output logic                           o_best_valid
);
    import srfs_pkg::*;

    localparam int FW    = $clog2(NUM_FACES);
    localparam int NUM_W = COUNT_BITS + PCT_EXTRA;
    localparam int SH_W  = COUNT_BITS + QUOT_BITS;
    localparam int STEP_W = $clog2(QUOT_BITS);

    // configuration
    logic [RATIO_W-1:0] r_thr;
    logic [TICKS_W-1:0] r_ticks;

    // captured item
    t_opcode            r_opcode;
    logic [FACE_W-1:0]  r_face;
    t_mask              r_elig;

    // timer
    logic [TICKS_W-1:0] r_wc;
    logic               r_running;

    // counters
    logic [COUNT_BITS-1:0] r_req_cnt [NUM_FACES];
    logic [COUNT_BITS-1:0] r_rsp_cnt [NUM_FACES];

    // walk and divider
    logic [FW-1:0]         r_face_idx;
    logic [NUM_W-1:0]      r_num;
    logic [COUNT_BITS-1:0] r_den;
    logic [COUNT_BITS-1:0] r_rem;
    logic [QUOT_BITS-1:0]  r_lo;
    logic [RATIO_W-1:0]    r_q;
    logic [STEP_W-1:0]     r_step;

    // best face
    logic [FW-1:0]      r_best_face;
    logic [RATIO_W-1:0] r_best_ratio;
    logic               r_best_valid;

    // result register
    logic               r_out_valid;
    t_mask              r_out_fwd;
    logic               r_out_flooded;
    logic [FACE_W-1:0]  r_out_best_face;
    logic               r_out_best_valid;

    logic                  is_req;
    logic                  is_rsp;
    logic                  is_tick;
    t_mask                 elig_m;
    t_mask                 best_sel;
    logic                  hit;
    t_mask                 fwd;
    logic [TICKS_W-1:0]    wc_inc;
    logic                  win_hit;
    logic [COUNT_BITS-1:0] cur_req;
    logic [COUNT_BITS-1:0] cur_rsp;
    logic [NUM_W-1:0]      rsp_wide;
    logic [COUNT_BITS:0]   rem2;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;
    logic [RATIO_W-1:0]    ratio_f;
    logic [31:0]           best_wide;
    logic                  out_write;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RATIO_W'(THRESH_RST);
            r_ticks <= TICKS_W'(TICKS_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RATIO_THRESHOLD: r_thr   <= i_cfg_data[RATIO_W-1:0];
                CFG_WINDOW_TICKS:    r_ticks <= i_cfg_data[TICKS_W-1:0];
                default:             r_thr   <= r_thr;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_opcode <= t_opcode'(i_opcode);
            r_face   <= i_face_index;
            r_elig   <= i_eligible_mask;
        end
    end

    assign is_req  = (r_opcode == OP_REQUEST);
    assign is_rsp  = (r_opcode == OP_RESPONSE);
    assign is_tick = (r_opcode == OP_TICK);

    // only faces that exist can be chosen
    for (genvar b = 0; b < MASK_FACES; b++) begin : g_elig
        if (b < NUM_FACES) begin : g_on
            assign elig_m[b] = r_elig[b];
        end else begin : g_off
            assign elig_m[b] = 1'b0;
        end
    end

    // forwarding decision: best face alone or flood
    assign best_sel = t_mask'(1) << r_best_face;
    assign hit      = r_best_valid && (r_best_ratio >= r_thr) && (|(best_sel & elig_m));
    assign fwd      = hit ? best_sel : elig_m;

    // window timer
    assign wc_inc  = r_wc + TICKS_W'(1);
    assign win_hit = (wc_inc >= r_ticks) || (wc_inc == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc      <= '0;
            r_running <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_wc <= '0;
        end else if (i_cmd.exec_item) begin
            if (is_req && !r_running) begin
                r_running <= 1'b1;
                r_wc      <= '0;
            end else if (is_tick && r_running) begin
                r_wc <= wc_inc;
            end
        end
    end

    // per-face saturating counters
    for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
        logic lane_req;
        logic lane_rsp;
        if (f < MASK_FACES) begin : g_sel
            assign lane_req = fwd[f];
        end else begin : g_nosel
            assign lane_req = 1'b0;
        end
        assign lane_rsp = (32'(r_face) == f);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.walk_finish) begin
                r_req_cnt[f] <= '0;
                r_rsp_cnt[f] <= '0;
            end else if (i_cmd.exec_item) begin
                if (is_req && lane_req && (r_req_cnt[f] != '1)) begin
                    r_req_cnt[f] <= r_req_cnt[f] + COUNT_BITS'(1);
                end
                if (is_rsp && lane_rsp && (r_rsp_cnt[f] != '1)) begin
                    r_rsp_cnt[f] <= r_rsp_cnt[f] + COUNT_BITS'(1);
                end
            end
        end
    end

    // face walk operands
    assign cur_req  = r_req_cnt[r_face_idx];
    assign cur_rsp  = r_rsp_cnt[r_face_idx];
    assign rsp_wide = NUM_W'(cur_rsp);

    // restoring division step
    assign rem2 = {r_rem, r_lo[QUOT_BITS-1]};
    assign ge   = (rem2 >= {1'b0, r_den});
    assign diff = rem2 - {1'b0, r_den};

    assign ratio_f = (r_q > RATIO_W'(RATIO_MAX)) ? RATIO_W'(RATIO_MAX) : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.face_load) begin
            // responses times one hundred
            r_num <= (rsp_wide << 6) + (rsp_wide << 5) + (rsp_wide << 2);
            r_den <= cur_req;
        end
        if (i_cmd.div_prep) begin
            if (o_status.div_sat) begin
                r_q <= RATIO_W'(RATIO_MAX);
            end else begin
                r_q <= '0;
            end
            r_rem  <= COUNT_BITS'(r_num >> QUOT_BITS);
            r_lo   <= r_num[QUOT_BITS-1:0];
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[COUNT_BITS-1:0] : rem2[COUNT_BITS-1:0];
            r_q    <= {r_q[RATIO_W-2:0], ge};
            r_lo   <= r_lo << 1;
            r_step <= r_step + STEP_W'(1);
        end
    end

    // walk index and running best, lowest face wins ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_idx   <= '0;
            r_best_face  <= '0;
            r_best_ratio <= '0;
            r_best_valid <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_face_idx   <= '0;
            r_best_face  <= '0;
            r_best_ratio <= '0;
            r_best_valid <= 1'b0;
        end else if (i_cmd.face_skip) begin
            r_face_idx <= r_face_idx + FW'(1);
        end else if (i_cmd.face_update) begin
            r_face_idx <= r_face_idx + FW'(1);
            if (!r_best_valid || (ratio_f > r_best_ratio)) begin
                r_best_valid <= 1'b1;
                r_best_ratio <= ratio_f;
                r_best_face  <= r_face_idx;
            end
        end
    end

    // status to controller
    assign o_status.win_end   = is_tick && r_running && win_hit;
    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_status.face_zero = (cur_req == '0);
    assign o_status.last_face = (r_face_idx == FW'(NUM_FACES - 1));
    assign o_status.div_sat   = (SH_W'(r_num) >= (SH_W'(r_den) << QUOT_BITS));
    assign o_status.div_last  = (r_step == STEP_W'(QUOT_BITS - 1));

    // result register
    assign best_wide = 32'(r_best_face);
    assign out_write = i_cmd.exec_item || i_cmd.walk_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_write) begin
            r_out_fwd        <= (i_cmd.exec_item && is_req) ? fwd : '0;
            r_out_flooded    <= i_cmd.exec_item && is_req && !hit;
            r_out_best_face  <= best_wide[FACE_W-1:0];
            r_out_best_valid <= r_best_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_forward_mask = r_out_fwd;
    assign o_flooded      = r_out_flooded;
    assign o_best_face    = r_out_best_face;
    assign o_best_valid   = r_out_best_valid;

endmodule

[hdl/satisfaction_ratio_face_selector_top.sv]
// top level of the satisfaction ratio face selector
// depends on srfs_pkg, srfs_ctrl and srfs_datapath
//
// Usage: one input item per handshake (i_valid / o_stall) carries an opcode
// (request, response, tick), a response face and an eligible-face mask; each
// item yields exactly one result item on o_valid / i_stall with the forward
// mask, flood flag and the current best face.
// Requests, responses and ticks that do not close a window are captured at
// acceptance and written to the result register once it is free; the next
// item is accepted only after that.
// A tick that closes a window walks every face through a shared 10-step
// restoring divider: faces without requests are skipped; a face with
// requests is loaded, prepared, divided (the division is bypassed when the
// ratio is capped) and compared with the best, then the result is written.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the ratio
// threshold or the window length.
// Reset (synchronous, active low) clears all counters, stored ratios, the
// timer and the result valid flag, and loads threshold 50 and window 999.
// While the receiver stalls, the result holds and one further item can be
// accepted; it then waits until the result register is free.
module satisfaction_ratio_face_selector_top #(
    parameter int NUM_FACES  = srfs_pkg::NUM_FACES_DEF,
    parameter int COUNT_BITS = srfs_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [srfs_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [srfs_pkg::OPC_W-1:0]      i_opcode,
    input  logic [srfs_pkg::FACE_W-1:0]     i_face_index,
    input  logic [srfs_pkg::MASK_FACES-1:0] i_eligible_mask,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [srfs_pkg::MASK_FACES-1:0] o_forward_mask,
    output logic                            o_flooded,
    output logic [srfs_pkg::FACE_W-1:0]     o_best_face,
    output logic                            o_best_valid
);
    import srfs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    srfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // counters, divider and result register
    srfs_datapath #(
        .NUM_FACES  (NUM_FACES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_face_index    (i_face_index),
        .i_eligible_mask (i_eligible_mask),
        .i_stall         (i_stall),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .o_forward_mask  (o_forward_mask),
        .o_flooded       (o_flooded),
        .o_best_face     (o_best_face),
        .o_best_valid    (o_best_valid)
    );

    // a request sent to the best face goes to that face alone
    a_single_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_flooded |-> $onehot0(o_forward_mask))
        else $error("non-flooded result names more than one face");

    // no best face is reported without a stored ratio
    a_best_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_best_valid |-> (o_best_face == '0))
        else $error("best face set without a stored ratio");

    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepting an item");

    // the controller issues at most one command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

endmodule

[test/tb_top.sv]
// testbench for the satisfaction ratio face selector: directed, saturation and random items
// depends on srfs_pkg and satisfaction_ratio_face_selector_top; checks every result item
`timescale 1ns / 1ps

module tb_top;
    import srfs_pkg::*;

    // timing and run length
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int TAIL_CYCLES  = 250;
    localparam int MAX_GAP      = 13;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 130;

    // narrow counters so saturation is reached in a few hundred items
    localparam int TB_COUNT_BITS = 8;

    // behaviour constants
    localparam int unsigned COUNT_MAX = (1 << TB_COUNT_BITS) - 1;
    localparam int unsigned PERCENT   = 100;
    localparam int          SAT_ITEMS = COUNT_MAX + 5;

    // the opcode value the block leaves without meaning
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        t_mask             fwd_mask;
        logic              flooded;
        logic [FACE_W-1:0] best_face;
        logic              best_valid;
    } t_face_result;

    // per-face counters, stored ratios and window timer, kept alongside the block
    class face_selector_scoreboard;
        int unsigned  req_cnt   [NUM_FACES_DEF];
        int unsigned  rsp_cnt   [NUM_FACES_DEF];
        int unsigned  ratio     [NUM_FACES_DEF];
        bit           has_ratio [NUM_FACES_DEF];
        int unsigned  win_cnt;
        bit           timer_on;
        int unsigned  thresh;
        int unsigned  win_len;
        t_face_result result_q [$];
        int           errors;
        int           n_items;
        int           n_req;
        int           n_flood;
        int           n_win_end;
        int           n_checked;

        function new();
            for (int f = 0; f < NUM_FACES_DEF; f++) begin
                req_cnt[f]   = 0;
                rsp_cnt[f]   = 0;
                ratio[f]     = 0;
                has_ratio[f] = 1'b0;
            end
            win_cnt   = 0;
            timer_on  = 1'b0;
            thresh    = THRESH_RST;
            win_len   = TICKS_RST;
            errors    = 0;
            n_items   = 0;
            n_req     = 0;
            n_flood   = 0;
            n_win_end = 0;
            n_checked = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            if (idx == CFG_RATIO_THRESHOLD)
                thresh = value[RATIO_W-1:0];
            else
                win_len = value[TICKS_W-1:0];
        endfunction

        // highest stored ratio, lowest face on ties
        function bit find_best(output int face);
            bit          found;
            int unsigned top;
            found = 1'b0;
            top   = 0;
            face  = 0;
            for (int f = 0; f < NUM_FACES_DEF; f++) begin
                if (has_ratio[f] && (!found || ratio[f] > top)) begin
                    found = 1'b1;
                    top   = ratio[f];
                    face  = f;
                end
            end
            return found;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // work out the result of an accepted item and update the counters
        function void note_item(logic [OPC_W-1:0] op, logic [FACE_W-1:0] face, t_mask mask);
            t_face_result    exp_r;
            int              bf;
            bit              bv;
            longint unsigned q;
            exp_r = '0;
            n_items++;
            if (op == OP_REQUEST) begin
                n_req++;
                if (!timer_on) begin
                    timer_on = 1'b1;
                    win_cnt  = 0;
                end
                bv = find_best(bf);
                if (bv && ratio[bf] >= thresh && mask[bf]) begin
                    exp_r.fwd_mask[bf] = 1'b1;
                end else begin
                    exp_r.fwd_mask = mask;
                    exp_r.flooded  = 1'b1;
                    n_flood++;
                end
                for (int f = 0; f < NUM_FACES_DEF; f++)
                    if (exp_r.fwd_mask[f] && req_cnt[f] < COUNT_MAX)
                        req_cnt[f]++;
            end else if (op == OP_RESPONSE) begin
                if (rsp_cnt[face] < COUNT_MAX)
                    rsp_cnt[face]++;
            end else if (op == OP_TICK && timer_on) begin
                win_cnt = (win_cnt + 1) & 32'hFFFF;
                // window end: store ratios of faces that saw requests, clear counters
                if (win_cnt >= win_len || win_cnt == 0) begin
                    win_cnt = 0;
                    n_win_end++;
                    for (int f = 0; f < NUM_FACES_DEF; f++) begin
                        if (req_cnt[f] != 0) begin
                            q = longint'(rsp_cnt[f]) * PERCENT / req_cnt[f];
                            ratio[f]     = (q > RATIO_MAX) ? RATIO_MAX : int'(q);
                            has_ratio[f] = 1'b1;
                        end else begin
                            ratio[f]     = 0;
                            has_ratio[f] = 1'b0;
                        end
                        req_cnt[f] = 0;
                        rsp_cnt[f] = 0;
                    end
                end
            end
            bv = find_best(bf);
            exp_r.best_valid = bv;
            exp_r.best_face  = bv ? bf[FACE_W-1:0] : '0;
            result_q.push_back(exp_r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(t_mask fwd, logic fl, logic [FACE_W-1:0] bf, logic bv);
            t_face_result exp_r;
            n_checked++;
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result item: fwd %h flooded %b best %0d valid %b",
                             fwd, fl, bf, bv);
                return;
            end
            exp_r = result_q.pop_front();
            if (exp_r.fwd_mask !== fwd || exp_r.flooded !== fl ||
                exp_r.best_face !== bf || exp_r.best_valid !== bv) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"result %0d mismatch: expected fwd %h flooded %b best %0d valid %b,",
                              " got fwd %h flooded %b best %0d valid %b"},
                             n_checked, exp_r.fwd_mask, exp_r.flooded, exp_r.best_face,
                             exp_r.best_valid, fwd, fl, bf, bv);
            end
        endfunction
    endclass

    // block ports
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic                  i_cfg_idx       = 1'b0;
    logic [CFG_W-1:0]      i_cfg_data      = '0;
    logic                  i_valid         = 1'b0;
    logic                  o_stall;
    logic [OPC_W-1:0]      i_opcode        = '0;
    logic [FACE_W-1:0]     i_face_index    = '0;
    t_mask                 i_eligible_mask = '0;
    logic                  o_valid;
    logic                  i_stall         = 1'b0;
    t_mask                 o_forward_mask;
    logic                  o_flooded;
    logic [FACE_W-1:0]     o_best_face;
    logic                  o_best_valid;

    face_selector_scoreboard sb;
    bit          no_gaps       = 1'b0;
    int          results_taken = 0;
    int          results_seen  = 0;
    int          stall_left    = 0;
    int unsigned cycle_count   = 0;

    satisfaction_ratio_face_selector_top #(
        .COUNT_BITS (TB_COUNT_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_face_index    (i_face_index),
        .i_eligible_mask (i_eligible_mask),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_forward_mask  (o_forward_mask),
        .o_flooded       (o_flooded),
        .o_best_face     (o_best_face),
        .o_best_valid    (o_best_valid)
    );

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // handshakes on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_forward_mask, o_flooded, o_best_face, o_best_valid);
                results_taken++;
            end
            if (i_valid && !o_stall)
                sb.note_item(i_opcode, i_face_index, i_eligible_mask);
        end
    end

    // receiver stalls a fresh random number of cycles per result item
    always @(negedge i_clk) begin
        if (results_taken != results_seen) begin
            results_seen = results_taken;
            stall_left   = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // present one item after a random gap and hold it until accepted
    task automatic send_item(logic [OPC_W-1:0] op, logic [FACE_W-1:0] face, t_mask mask);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_opcode        <= op;
        i_face_index    <= face;
        i_eligible_mask <= mask;
        i_valid         <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
    endtask

    // stop sending and wait until every expected result has come back
    task automatic hold_off();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // random traffic under one register setting
    task automatic run_random_phase(int thresh, int win, int n_items);
        int                counted;
        int                pick;
        bit                paused;
        logic [OPC_W-1:0]  op;
        logic [FACE_W-1:0] face;
        t_mask             mask;
        counted = 0;
        paused  = 1'b0;
        hold_off();
        write_reg(CFG_RATIO_THRESHOLD, CFG_W'(thresh));
        write_reg(CFG_WINDOW_TICKS, CFG_W'(win));
        while (counted < n_items) begin
            // every third stretch of forty items runs with no idling
            no_gaps = ((counted / 40) % 3 == 2);
            if (!paused && counted >= n_items / 2) begin
                paused = 1'b1;
                hold_off();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_REQUEST;
            else if (pick < 75)
                op = OP_RESPONSE;
            else if (pick < 95)
                op = OP_TICK;
            else
                op = OP_UNUSED;
            // responses crowd onto the low faces half the time to push ratios up
            face = $urandom_range(0, 1) ? FACE_W'($urandom_range(0, 3))
                                        : FACE_W'($urandom_range(0, 15));
            case ($urandom_range(0, 15))
                0:          mask = '0;
                1:          mask = '1;
                2, 3, 4, 5: mask = t_mask'(1) << $urandom_range(0, 15);
                default:    mask = t_mask'($urandom);
            endcase
            send_item(op, face, mask);
            if (op != OP_UNUSED)
                counted++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ticks before the timer starts, unused opcode, empty mask, no stored ratio
        send_item(OP_TICK, 4'd0, 16'hFFFF);
        send_item(OP_UNUSED, 4'd15, 16'hFFFF);
        send_item(OP_RESPONSE, 4'd15, 16'h0000);
        send_item(OP_REQUEST, 4'd0, 16'h0000);
        send_item(OP_REQUEST, 4'd5, 16'hFFFF);
        send_item(OP_REQUEST, 4'd0, 16'h8000);
        repeat (3) send_item(OP_RESPONSE, 4'd15, 16'h5555);
        send_item(OP_RESPONSE, 4'd2, 16'hAAAA);
        // zero window length closes on the next tick
        hold_off();
        write_reg(CFG_WINDOW_TICKS, 16'd0);
        send_item(OP_TICK, 4'd9, 16'h1234);
        // best face barred, then best face allowed
        send_item(OP_REQUEST, 4'd3, 16'h7FFF);
        send_item(OP_REQUEST, 4'd3, 16'h8001);
        // best ratio below a threshold of 1000
        hold_off();
        write_reg(CFG_RATIO_THRESHOLD, 16'd1000);
        send_item(OP_REQUEST, 4'd12, 16'hFFFF);

        // counter saturation on face 3, ratio cap on face 4, back to back
        hold_off();
        write_reg(CFG_WINDOW_TICKS, 16'hFFFF);
        write_reg(CFG_RATIO_THRESHOLD, 16'd50);
        no_gaps = 1'b1;
        for (int i = 0; i < SAT_ITEMS; i++)
            send_item(OP_REQUEST, FACE_W'($urandom_range(0, 15)), 16'h0008);
        for (int i = 0; i < SAT_ITEMS; i++)
            send_item(OP_RESPONSE, 4'd3, t_mask'($urandom));
        send_item(OP_REQUEST, 4'd0, 16'h0010);
        repeat (40) send_item(OP_RESPONSE, 4'd4, t_mask'($urandom));
        no_gaps = 1'b0;
        // shorten the window so the running count closes it at once
        hold_off();
        write_reg(CFG_WINDOW_TICKS, 16'd1);
        send_item(OP_TICK, 4'd0, 16'h0000);
        // a ratio exactly at the threshold goes to the best face alone
        hold_off();
        write_reg(CFG_RATIO_THRESHOLD, 16'd1000);
        send_item(OP_REQUEST, 4'd1, 16'h0010);
        send_item(OP_REQUEST, 4'd1, 16'h0008);

        // random phases across register extremes and mid values
        run_random_phase(0, 1, PHASE_ITEMS);
        run_random_phase($urandom_range(1, 120), $urandom_range(2, 12), PHASE_ITEMS);
        run_random_phase(1000, 65535, PHASE_ITEMS);
        run_random_phase(100, 3, PHASE_ITEMS);
        run_random_phase($urandom_range(0, 1000), $urandom_range(1, 40), PHASE_ITEMS);

        // drain, then give a window close time to show any stray result
        hold_off();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0d expected result items never arrived", sb.pending());
        $display("ran %0d items: %0d requests, %0d of them flooded, %0d windows closed",
                 sb.n_items, sb.n_req, sb.n_flood, sb.n_win_end);
        $display("checked %0d result items, %0d failures", sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[satisfaction_ratio_face_selector_top.f]
hdl/srfs_pkg.sv
hdl/srfs_ctrl.sv
hdl/srfs_datapath.sv
hdl/satisfaction_ratio_face_selector_top.sv
test/tb_top.sv
